[hdl/sthr_pkg.sv]
// Shared types and constants for the slot table with hole reuse.
package sthr_pkg;

	localparam int unsigned CAPACITY_DEF    = 256;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam int unsigned OP_W            = 3;
	localparam int unsigned IDX_W           = 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH      = 3'd0,
		OP_POP       = 3'd1,
		OP_READ      = 3'd2,
		OP_WRITE     = 3'd3,
		OP_DELETE    = 3'd4,
		OP_READ_LAST = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// decoded request handed from the front to the back
	typedef struct packed {
		logic             mem_en;
		logic             wr_en;
		logic             use_rd;
		status_t          status;
		logic [IDX_W-1:0] out_index;
	} ctl_t;

endpackage

[hdl/sthr_front.sv]
// Front end: checks each request against count and hole, keeps both registers.
module sthr_front import sthr_pkg::*; #(
	parameter int unsigned CAPACITY    = CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int unsigned AW    = $clog2(CAPACITY),
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [OP_W-1:0]        op,
	input  logic [IDX_W-1:0]       slot_index,
	input  logic [VALUE_WIDTH-1:0] value,
	output ctl_t                   ctl,
	output logic [AW-1:0]          addr,
	output logic [VALUE_WIDTH-1:0] wdata,
	output logic [CNT_W-1:0]       count_after
);

	localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] hole_q;
	logic [IDX_W-1:0] hole_next;
	logic             in_range;
	logic             hole_ok;
	logic             not_empty;
	logic [CNT_W-1:0] last;

	assign in_range  = CMP_W'(slot_index) < CMP_W'(count_q);
	assign hole_ok   = (hole_q != '0) && (CMP_W'(hole_q) < CMP_W'(count_q));
	assign not_empty = count_q != '0;
	assign last      = count_q - CNT_W'(1);

	always_comb begin
		ctl         = '{mem_en: 1'b0, wr_en: 1'b0, use_rd: 1'b0,
		                status: ST_RANGE, out_index: '0};
		addr        = '0;
		wdata       = '0;
		count_after = count_q;
		hole_next   = hole_q;
		case (op)
			OP_PUSH: begin
				if (hole_ok) begin
					ctl.mem_en    = 1'b1;
					ctl.wr_en     = 1'b1;
					ctl.status    = ST_OK;
					ctl.out_index = hole_q;
					addr          = AW'(hole_q);
					wdata         = value;
					hole_next     = '0;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.mem_en    = 1'b1;
					ctl.wr_en     = 1'b1;
					ctl.status    = ST_OK;
					ctl.out_index = IDX_W'(count_q);
					addr          = AW'(count_q);
					wdata         = value;
					count_after   = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (not_empty) begin
					// read-before-write returns the old entry and clears it
					ctl.mem_en  = 1'b1;
					ctl.wr_en   = 1'b1;
					ctl.use_rd  = 1'b1;
					ctl.status  = ST_OK;
					addr        = AW'(last);
					count_after = last;
				end
			end
			OP_READ: begin
				if (in_range) begin
					ctl.mem_en = 1'b1;
					ctl.use_rd = 1'b1;
					ctl.status = ST_OK;
					addr       = AW'(slot_index);
				end
			end
			OP_WRITE: begin
				if (in_range) begin
					ctl.mem_en = 1'b1;
					ctl.wr_en  = 1'b1;
					ctl.status = ST_OK;
					addr       = AW'(slot_index);
					wdata      = value;
				end
			end
			OP_DELETE: begin
				if (in_range) begin
					ctl.mem_en = 1'b1;
					ctl.wr_en  = 1'b1;
					ctl.status = ST_OK;
					addr       = AW'(slot_index);
					hole_next  = slot_index;
				end
			end
			OP_READ_LAST: begin
				if (not_empty) begin
					ctl.mem_en = 1'b1;
					ctl.use_rd = 1'b1;
					ctl.status = ST_OK;
					addr       = AW'(last);
				end
			end
			default: begin
				ctl.status = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hole_q  <= '0;
		end else if (take) begin
			count_q <= count_after;
			hole_q  <= hole_next;
		end
	end

endmodule

[hdl/sthr_queue.sv]
// Short request queue between front and back.
module sthr_queue import sthr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH,
	parameter int unsigned WIDTH = 8,
	localparam int unsigned PW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             ready,
	output logic             valid,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign ready   = cnt_q != CW'(DEPTH);
	assign valid   = cnt_q != '0;
	assign do_wr   = wr_en && ready;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

[hdl/sthr_back.sv]
// Back end: slot memory access, read data merge and result register.
module sthr_back import sthr_pkg::*; #(
	parameter int unsigned CAPACITY    = CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int unsigned AW    = $clog2(CAPACITY),
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  ctl_t                   cmd_ctl,
	input  logic [AW-1:0]          cmd_addr,
	input  logic [VALUE_WIDTH-1:0] cmd_wdata,
	input  logic [CNT_W-1:0]       cmd_count,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             status,
	output logic [IDX_W-1:0]       out_index,
	output logic [VALUE_WIDTH-1:0] out_value,
	output logic [CNT_W-1:0]       element_count
);

	logic [VALUE_WIDTH-1:0] slots [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_q;

	logic                   valid_s1;
	ctl_t                   ctl_s1;
	logic [VALUE_WIDTH-1:0] wdata_s1;
	logic [CNT_W-1:0]       count_s1;

	logic                   out_valid_q;
	status_t                status_q;
	logic [IDX_W-1:0]       out_index_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [CNT_W-1:0]       count_q;

	logic                   pop_ok;
	logic                   move_s1;
	logic                   issue;
	logic [VALUE_WIDTH-1:0] merged;

	assign pop_ok    = pop && out_valid_q;
	assign move_s1   = valid_s1 && (!out_valid_q || pop_ok);
	assign cmd_ready = !valid_s1 || move_s1;
	assign issue     = cmd_valid && cmd_ready;
	assign merged    = ctl_s1.use_rd ? rd_q : (ctl_s1.wr_en ? wdata_s1 : '0);

	// single port, old data out when reading and writing the same slot
	always_ff @(posedge clk) begin
		if (issue && cmd_ctl.mem_en) begin
			rd_q <= slots[cmd_addr];
			if (cmd_ctl.wr_en)
				slots[cmd_addr] <= cmd_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ctl_s1   <= cmd_ctl;
			wdata_s1 <= cmd_wdata;
			count_s1 <= cmd_count;
		end
		if (move_s1) begin
			status_q    <= ctl_s1.status;
			out_index_q <= ctl_s1.out_index;
			out_value_q <= merged;
			count_q     <= count_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue)
				valid_s1 <= 1'b1;
			else if (move_s1)
				valid_s1 <= 1'b0;
			if (move_s1)
				out_valid_q <= 1'b1;
			else if (pop_ok)
				out_valid_q <= 1'b0;
		end
	end

	assign empty         = !out_valid_q;
	assign status        = status_q;
	assign out_index     = out_index_q;
	assign out_value     = out_value_q;
	assign element_count = count_q;

endmodule

[hdl/slot_table_with_hole_reuse.sv]
// Top level of the slot table with hole reuse.
//
//   channel   handshake        fields
//   request   push / full      op, slot_index, value
//   result    empty / pop      status, out_index, out_value, element_count
//
// One request per cycle while results are popped; a result reaches the ports once its
// request is queued, issued to memory and then loaded into the result register.
// Throughput is set by the single slot memory port, at most one access per request.
// Reset clears count, hole and all handshake state; slot contents stay undefined.
// A held result backs up into the two-entry request queue, then full rises.
module slot_table_with_hole_reuse import sthr_pkg::*; #(
	parameter int unsigned CAPACITY    = CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int unsigned AW    = $clog2(CAPACITY),
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [OP_W-1:0]        op,
	input  logic [IDX_W-1:0]       slot_index,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             status,
	output logic [IDX_W-1:0]       out_index,
	output logic [VALUE_WIDTH-1:0] out_value,
	output logic [CNT_W-1:0]       element_count
);

	localparam int unsigned QW = $bits(ctl_t) + AW + VALUE_WIDTH + CNT_W;

	logic                   take;
	logic                   q_ready;
	logic                   q_valid;
	logic                   q_rd;
	ctl_t                   f_ctl;
	logic [AW-1:0]          f_addr;
	logic [VALUE_WIDTH-1:0] f_wdata;
	logic [CNT_W-1:0]       f_count;
	logic [QW-1:0]          q_wr_data;
	logic [QW-1:0]          q_rd_data;
	ctl_t                   b_ctl;
	logic [AW-1:0]          b_addr;
	logic [VALUE_WIDTH-1:0] b_wdata;
	logic [CNT_W-1:0]       b_count;

	assign full = !q_ready;
	assign take = push && q_ready;

	sthr_front #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.op         (op),
		.slot_index (slot_index),
		.value      (value),
		.ctl        (f_ctl),
		.addr       (f_addr),
		.wdata      (f_wdata),
		.count_after(f_count)
	);

	assign q_wr_data = {f_ctl, f_addr, f_wdata, f_count};

	sthr_queue #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (take),
		.wr_data(q_wr_data),
		.ready  (q_ready),
		.valid  (q_valid),
		.rd_en  (q_rd),
		.rd_data(q_rd_data)
	);

	assign {b_ctl, b_addr, b_wdata, b_count} = q_rd_data;

	sthr_back #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_rd),
		.cmd_ctl      (b_ctl),
		.cmd_addr     (b_addr),
		.cmd_wdata    (b_wdata),
		.cmd_count    (b_count),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.out_index    (out_index),
		.out_value    (out_value),
		.element_count(element_count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> element_count <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_full_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> element_count == CNT_W'(CAPACITY))
		else $error("full status while table not at capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (out_index == '0 && out_value == '0))
		else $error("failed request carries nonzero payload");

	a_queued: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> q_valid)
		else $error("accepted request missing from queue");

endmodule
